FILE: hdl/wpl_pkg.sv
// shared constants and types for the windowed pid lateral rate controller
package wpl_pkg;

  localparam int DATA_W     = 32;
  localparam int DIST_W     = 31;
  localparam int LIM_W      = 31;
  localparam int DEF_WINDOW = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KP           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_PER_TICK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_TIMES_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

  // deadband thresholds, Q16.16
  localparam int DB_SMALL     = 229;     // 0.0035
  localparam int DB_WIDE      = 1311;    // 0.02
  localparam int DB_NEAR_DIST = 229376;  // 3.5 m

  typedef struct packed {
    logic deadbanded;
    logic clamped;
    logic rate_limited;
  } wpl_flags_t;

endpackage

FILE: hdl/wpl_window.sv
// error ring, running window sum and error difference, first register stage
module wpl_window #(
  parameter int WINDOW = wpl_pkg::DEF_WINDOW,
  localparam int SUM_W = wpl_pkg::DATA_W + $clog2(WINDOW)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [wpl_pkg::DATA_W-1:0]   e_i,
  input  logic        [wpl_pkg::DIST_W-1:0]   dist_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wpl_pkg::DATA_W-1:0]   e_o,
  output logic signed [SUM_W-1:0]             sum_o,
  output logic signed [wpl_pkg::DATA_W:0]     diff_o,
  output logic        [wpl_pkg::DIST_W-1:0]   dist_o
);
  import wpl_pkg::*;

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic signed [DATA_W-1:0] mem [WINDOW];
  logic signed [DATA_W-1:0] rd_q;
  logic [PTR_W-1:0]         ptr_q, ptr_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SUM_W-1:0]  run_sum_q, run_sum_d;
  logic signed [DATA_W-1:0] prev_err_q;
  logic                     full;
  logic                     acc;
  logic                     v_q;
  logic signed [SUM_W-1:0]  old_x;
  logic signed [DATA_W:0]   diff_d;

  logic signed [DATA_W-1:0] e_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DATA_W:0]   diff_q;
  logic [DIST_W-1:0]        dist_q;

  assign in_ready_o = !v_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CNT_W'(WINDOW));

  always_comb begin
    ptr_d = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
    cnt_d = full ? cnt_q : cnt_q + CNT_W'(1);
    // drop the oldest entry once the ring is full
    old_x     = full ? SUM_W'(rd_q) : '0;
    run_sum_d = run_sum_q - old_x + SUM_W'(e_i);
    diff_d    = (DATA_W+1)'(e_i) - (DATA_W+1)'(prev_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      cnt_q      <= '0;
      run_sum_q  <= '0;
      prev_err_q <= '0;
      v_q        <= 1'b0;
    end else begin
      if (acc) begin
        ptr_q      <= ptr_d;
        cnt_q      <= cnt_d;
        run_sum_q  <= run_sum_d;
        prev_err_q <= e_i;
        v_q        <= 1'b1;
      end else if (out_ready_i) begin
        v_q <= 1'b0;
      end
    end
  end

  // ring store, next oldest entry fetched ahead of the following item
  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem[ptr_q] <= e_i;
      rd_q       <= (ptr_d == ptr_q) ? e_i : mem[ptr_d];
      e_q        <= e_i;
      sum_q      <= run_sum_d;
      diff_q     <= diff_d;
      dist_q     <= dist_i;
    end
  end

  assign out_valid_o = v_q;
  assign e_o         = e_q;
  assign sum_o       = sum_q;
  assign diff_o      = diff_q;
  assign dist_o      = dist_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW))
    else $error("window count beyond window depth");
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(WINDOW - 1))
    else $error("ring pointer out of range");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !full |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("window count did not advance during warm-up");
`endif

endmodule

FILE: hdl/wpl_terms.sv
// three gain products and their sum, two register stages
module wpl_terms #(
  parameter int WINDOW = wpl_pkg::DEF_WINDOW,
  localparam int SUM_W = wpl_pkg::DATA_W + $clog2(WINDOW),
  localparam int Y_W   = SUM_W + 19
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [wpl_pkg::DATA_W-1:0]   kp_i,
  input  logic signed [wpl_pkg::DATA_W-1:0]   ki_i,
  input  logic signed [wpl_pkg::DATA_W-1:0]   kd_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [wpl_pkg::DATA_W-1:0]   e_i,
  input  logic signed [SUM_W-1:0]             sum_i,
  input  logic signed [wpl_pkg::DATA_W:0]     diff_i,
  input  logic        [wpl_pkg::DIST_W-1:0]   dist_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [Y_W-1:0]               y_o,
  output logic        [wpl_pkg::DIST_W-1:0]   dist_o
);
  import wpl_pkg::*;

  localparam int PKP_W = 2 * DATA_W;
  localparam int PKI_W = DATA_W + SUM_W;
  localparam int PKD_W = 2 * DATA_W + 1;

  logic signed [PKP_W-1:0] prod_kp;
  logic signed [PKI_W-1:0] prod_ki;
  logic signed [PKD_W-1:0] prod_kd;

  // products floored by 2^-16: dropping the low bits of a two's complement value
  logic signed [PKP_W-17:0] t_kp_q;
  logic signed [PKI_W-17:0] t_ki_q;
  logic signed [PKD_W-17:0] t_kd_q;
  logic [DIST_W-1:0]        dist2_q;
  logic                     v2_q, rdy2;

  logic signed [Y_W-1:0]    y_d, y_q;
  logic [DIST_W-1:0]        dist3_q;
  logic                     v3_q, rdy3;

  assign prod_kp = kp_i * e_i;
  assign prod_ki = ki_i * sum_i;
  assign prod_kd = kd_i * diff_i;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  assign y_d = Y_W'(t_kp_q) + Y_W'(t_ki_q) + Y_W'(t_kd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= in_valid_i;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      t_kp_q  <= prod_kp[PKP_W-1:16];
      t_ki_q  <= prod_ki[PKI_W-1:16];
      t_kd_q  <= prod_kd[PKD_W-1:16];
      dist2_q <= dist_i;
    end
    if (rdy3 && v2_q) begin
      y_q     <= y_d;
      dist3_q <= dist2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign y_o         = y_q;
  assign dist_o      = dist3_q;

endmodule

FILE: hdl/wpl_limit.sv
// step limit, magnitude clamp, deadband and the result register
module wpl_limit #(
  parameter int WINDOW = wpl_pkg::DEF_WINDOW,
  localparam int SUM_W = wpl_pkg::DATA_W + $clog2(WINDOW),
  localparam int Y_W   = SUM_W + 19
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic        [wpl_pkg::LIM_W-1:0]    step_limit_i,
  input  logic        [wpl_pkg::LIM_W-1:0]    output_limit_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [Y_W-1:0]               y_i,
  input  logic        [wpl_pkg::DIST_W-1:0]   dist_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wpl_pkg::DATA_W-1:0]   drive_o,
  output wpl_pkg::wpl_flags_t                 flags_o
);
  import wpl_pkg::*;

  localparam int L = Y_W + 1;

  logic signed [DATA_W-1:0] prev_out_q;
  logic signed [DATA_W-1:0] drive_q;
  wpl_flags_t               flags_q;
  logic                     v_q, adv;

  logic signed [L-1:0] prev_x, stp, ol, dlt, sv, cv, ay;
  logic                rl, cl, db_hit;
  logic signed [DATA_W-1:0] res;
  wpl_flags_t          flags_d;

  assign in_ready_o = !v_q || out_ready_i;
  assign adv        = in_valid_i && in_ready_o;

  always_comb begin
    prev_x = L'(prev_out_q);
    stp    = L'(signed'({1'b0, step_limit_i}));
    ol     = L'(signed'({1'b0, output_limit_i}));
    dlt    = L'(y_i) - prev_x;
    rl     = 1'b0;
    cl     = 1'b0;
    // change from the last result held within the step limit
    if (dlt > stp) begin
      sv = prev_x + stp;
      rl = 1'b1;
    end else if (dlt < -stp) begin
      sv = prev_x - stp;
      rl = 1'b1;
    end else begin
      sv = L'(y_i);
    end
    if (sv > ol) begin
      cv = ol;
      cl = 1'b1;
    end else if (sv < -ol) begin
      cv = -ol;
      cl = 1'b1;
    end else begin
      cv = sv;
    end
    ay     = cv[L-1] ? -cv : cv;
    // wider band only near the aim point
    db_hit = (ay < L'(DB_SMALL)) ||
             ((ay < L'(DB_WIDE)) && (dist_i < DIST_W'(DB_NEAR_DIST)));
    res    = db_hit ? '0 : cv[DATA_W-1:0];
    flags_d.rate_limited = rl;
    flags_d.clamped      = cl;
    flags_d.deadbanded   = db_hit && (cv != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q        <= 1'b0;
      prev_out_q <= '0;
    end else begin
      if (adv) begin
        v_q        <= 1'b1;
        prev_out_q <= res;
      end else if (out_ready_i) begin
        v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drive_q <= res;
      flags_q <= flags_d;
    end
  end

  assign out_valid_o = v_q;
  assign drive_o     = drive_q;
  assign flags_o     = flags_q;

`ifndef SYNTH
  a_db_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && flags_q.deadbanded |-> drive_q == '0)
    else $error("deadbanded item carries a nonzero command");
  a_prev_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> prev_out_q == drive_q)
    else $error("last output state differs from the waiting result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !out_ready_i |=> v_q && $stable(drive_q) && $stable(flags_q))
    else $error("waiting result changed before it was taken");
`endif

endmodule

FILE: hdl/windowed_pid_lateral_rate_top.sv
// top level of the windowed pid lateral rate controller
//
//  port group      dir  payload (lowest bit first)
//  s_axis_*        in   tdata: error_angle[31:0], target_distance[62:32], zero[63]
//  m_axis_*        out  tdata: drive_rate[31:0]; tuser: rate_limited, clamped, deadbanded
//  cfg_*           in   write enable, register index, 32-bit data
//
// one item per cycle sustained while m_axis_tready stays high
// stage one updates the error ring and running sum on accept, stage two holds the
// three products, stage three their sum, the result register takes the limited value
// the step limit loop closes through the last-result register, loaded with each result
// reset zeroes the gains, sets the limits to full scale, clears all history but the ring
// each stage stalls only when it is full and the stage after it cannot take an item
module windowed_pid_lateral_rate_top #(
  parameter int WINDOW = wpl_pkg::DEF_WINDOW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [63:0]                       s_axis_tdata,  // error_angle, target_distance
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // drive_rate
  output logic [2:0]                        m_axis_tuser,  // rate_limited, clamped, deadbanded
  input  logic                              cfg_we_i,
  input  logic [wpl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wpl_pkg::DATA_W-1:0]        cfg_data_i
);
  import wpl_pkg::*;

  localparam int SUM_W = DATA_W + $clog2(WINDOW);
  localparam int Y_W   = SUM_W + 19;

  // configuration registers
  logic signed [DATA_W-1:0] kp_q, ki_q, kd_q;
  logic [LIM_W-1:0]         step_q, olim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      step_q <= '1;
      olim_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:            kp_q   <= cfg_data_i;
        REG_KI_PER_TICK:   ki_q   <= cfg_data_i;
        REG_KD_TIMES_RATE: kd_q   <= cfg_data_i;
        REG_STEP_LIMIT:    step_q <= cfg_data_i[LIM_W-1:0];
        REG_OUTPUT_LIMIT:  olim_q <= cfg_data_i[LIM_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // window stage to product stages
  logic                     w_valid, w_ready;
  logic signed [DATA_W-1:0] w_e;
  logic signed [SUM_W-1:0]  w_sum;
  logic signed [DATA_W:0]   w_diff;
  logic [DIST_W-1:0]        w_dist;

  // product stages to limiter
  logic                     t_valid, t_ready;
  logic signed [Y_W-1:0]    t_y;
  logic [DIST_W-1:0]        t_dist;

  logic signed [DATA_W-1:0] drive;
  wpl_flags_t               flags;

  wpl_window #(.WINDOW(WINDOW)) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .e_i         (s_axis_tdata[31:0]),
    .dist_i      (s_axis_tdata[62:32]),
    .out_valid_o (w_valid),
    .out_ready_i (w_ready),
    .e_o         (w_e),
    .sum_o       (w_sum),
    .diff_o      (w_diff),
    .dist_o      (w_dist)
  );

  wpl_terms #(.WINDOW(WINDOW)) u_terms (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kp_i        (kp_q),
    .ki_i        (ki_q),
    .kd_i        (kd_q),
    .in_valid_i  (w_valid),
    .in_ready_o  (w_ready),
    .e_i         (w_e),
    .sum_i       (w_sum),
    .diff_i      (w_diff),
    .dist_i      (w_dist),
    .out_valid_o (t_valid),
    .out_ready_i (t_ready),
    .y_o         (t_y),
    .dist_o      (t_dist)
  );

  wpl_limit #(.WINDOW(WINDOW)) u_limit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_limit_i   (step_q),
    .output_limit_i (olim_q),
    .in_valid_i     (t_valid),
    .in_ready_o     (t_ready),
    .y_i            (t_y),
    .dist_i         (t_dist),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .drive_o        (drive),
    .flags_o        (flags)
  );

  assign m_axis_tdata = drive;
  assign m_axis_tuser = {flags.deadbanded, flags.clamped, flags.rate_limited};

endmodule

FILE: verif/tb_windowed_pid_lateral_rate_top.sv
// self-checking testbench for the windowed pid lateral rate controller, random and directed ticks
module tb_windowed_pid_lateral_rate_top;
  import wpl_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  // one control tick as it goes into the block
  typedef struct {
    logic signed [DATA_W-1:0] err;
    logic [DIST_W-1:0]        tgt_dist;
  } tick_t;

  // one expected rate command with its limiter flags
  typedef struct packed {
    logic [DATA_W-1:0] drive_rate;
    wpl_flags_t        flags;
  } rate_cmd_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata  = '0;  // error_angle, target_distance, zero pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;        // drive_rate
  logic [2:0]           m_axis_tuser;        // rate_limited, clamped, deadbanded
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  // pending ticks for the source, commands still owed by the block
  tick_t     tick_q[$];
  rate_cmd_t cmd_q[$];

  int fail_cnt  = 0;
  int src_wait  = 0;
  int snk_wait  = 0;
  int cycle_cnt = 0;
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;

  // mirror of the controller registers, reset values
  logic signed [DATA_W-1:0] gain_p   = '0;
  logic signed [DATA_W-1:0] gain_i   = '0;
  logic signed [DATA_W-1:0] gain_d   = '0;
  logic [LIM_W-1:0]         step_lim = '1;
  logic [LIM_W-1:0]         out_lim  = '1;

  // mirror of the controller history
  logic signed [DATA_W-1:0] err_ring [DEF_WINDOW];
  int                       ring_wr  = 0;
  int                       win_fill = 0;
  logic signed [63:0]       win_sum  = '0;
  logic signed [63:0]       last_err = '0;
  logic signed [63:0]       last_out = '0;

  windowed_pid_lateral_rate_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // works out the rate command for one tick and advances the mirrored history
  function automatic void predict_rate_command(input logic signed [DATA_W-1:0] err,
                                               input logic [DIST_W-1:0] tgt_dist);
    logic signed [127:0] a, b, raw;
    logic signed [63:0]  y, ay, lim_s, lim_o, err_w;
    rate_cmd_t           cmd;
    err_w = err;
    cmd   = '0;
    // sliding window: drop the oldest error once the ring is full
    if (win_fill >= DEF_WINDOW) begin
      win_sum = win_sum - err_ring[ring_wr];
    end else begin
      win_fill++;
    end
    err_ring[ring_wr] = err;
    win_sum = win_sum + err_w;
    ring_wr = (ring_wr + 1) % DEF_WINDOW;
    // q16.16 products, floor rounding through the arithmetic shift
    a = gain_p;
    b = err_w;
    raw = (a * b) >>> 16;
    a = gain_i;
    b = win_sum;
    raw = raw + ((a * b) >>> 16);
    a = gain_d;
    b = err_w - last_err;
    raw = raw + ((a * b) >>> 16);
    y = raw[63:0];
    // step limit against the last command
    lim_s = {33'd0, step_lim};
    if (y - last_out > lim_s) begin
      y = last_out + lim_s;
      cmd.flags.rate_limited = 1'b1;
    end else if (y - last_out < -lim_s) begin
      y = last_out - lim_s;
      cmd.flags.rate_limited = 1'b1;
    end
    // magnitude clamp
    lim_o = {33'd0, out_lim};
    if (y > lim_o) begin
      y = lim_o;
      cmd.flags.clamped = 1'b1;
    end else if (y < -lim_o) begin
      y = -lim_o;
      cmd.flags.clamped = 1'b1;
    end
    // deadband, wider when the aim point is close
    ay = (y < 0) ? -y : y;
    if (ay < DB_SMALL || (ay < DB_WIDE && tgt_dist < DB_NEAR_DIST)) begin
      cmd.flags.deadbanded = (y != 0);
      y = '0;
    end
    last_err = err_w;
    last_out = y;
    cmd.drive_rate = y[DATA_W-1:0];
    cmd_q = {cmd_q, cmd};
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int idle_len(input bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    logic [DATA_W-1:0] g;
    case ($urandom_range(0, 9))
      0: g = 32'h8000_0000;
      1: g = 32'h7FFF_FFFF;
      2: g = '0;
      3: g = $urandom();
      default: begin
        g = $urandom_range(0, 32'h0003_0000);
        if ($urandom_range(0, 1)) g = -g;
      end
    endcase
    return g;
  endfunction

  // limits are 31 bits wide, the top bit of the write data is noise
  function automatic logic [DATA_W-1:0] rand_limit();
    logic [DATA_W-1:0] g;
    case ($urandom_range(0, 7))
      0: g = '0;
      1: g = 32'h7FFF_FFFF;
      2: g = $urandom();
      3: g = $urandom_range(1, 32'h2000);
      default: g = $urandom_range(32'h800, 32'h8_0000);
    endcase
    g[DATA_W-1] = $urandom_range(0, 1);
    return g;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    case ($urandom_range(0, 9))
      0: t.err = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: t.err = $urandom();
      2, 3: begin
        t.err = $urandom_range(0, 32'h800);
        if ($urandom_range(0, 1)) t.err = -t.err;
      end
      default: begin
        t.err = $urandom_range(0, 32'h2_0000);
        if ($urandom_range(0, 1)) t.err = -t.err;
      end
    endcase
    case ($urandom_range(0, 5))
      0: t.tgt_dist = DIST_W'($urandom());
      1: t.tgt_dist = DIST_W'(DB_NEAR_DIST - 1 + $urandom_range(0, 1));
      default: t.tgt_dist = DIST_W'($urandom_range(0, 2 * DB_NEAR_DIST));
    endcase
    return t;
  endfunction

  // source: one item per handshake, random gaps drawn per item
  always @(posedge clk_i) begin : source
    tick_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_wait      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_rate_command(s_axis_tdata[DATA_W-1:0], s_axis_tdata[DATA_W+DIST_W-1:DATA_W]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0) begin
          s_axis_tvalid <= 1'b0;
          src_wait      <= src_wait - 1;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q[0];
          tick_q.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, nxt.tgt_dist, nxt.err};
          src_wait      <= idle_len(src_idle_on);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink: random back-pressure, every accepted item checked against the oldest expectation
  always @(posedge clk_i) begin : sink
    rate_cmd_t want;
    int        len;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_wait      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_q.size() == 0) begin
          $error("drive_rate item with nothing expected: actual %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = cmd_q[0];
          cmd_q.delete(0);
          if (m_axis_tdata !== want.drive_rate) begin
            $error("drive_rate: expected %h actual %h", want.drive_rate, m_axis_tdata);
            fail_cnt++;
          end
          if (m_axis_tuser[0] !== want.flags.rate_limited) begin
            $error("rate_limited: expected %b actual %b", want.flags.rate_limited,
                   m_axis_tuser[0]);
            fail_cnt++;
          end
          if (m_axis_tuser[1] !== want.flags.clamped) begin
            $error("clamped: expected %b actual %b", want.flags.clamped, m_axis_tuser[1]);
            fail_cnt++;
          end
          if (m_axis_tuser[2] !== want.flags.deadbanded) begin
            $error("deadbanded: expected %b actual %b", want.flags.deadbanded,
                   m_axis_tuser[2]);
            fail_cnt++;
          end
        end
      end
      if (snk_wait > 0) begin
        m_axis_tready <= 1'b0;
        snk_wait      <= snk_wait - 1;
      end else begin
        len = idle_len(snk_idle_on);
        m_axis_tready <= (len == 0);
        snk_wait      <= (len > 0) ? len - 1 : 0;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // register write, mirrored straight away since the block is idle
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_KP:            gain_p   = val;
      REG_KI_PER_TICK:   gain_i   = val;
      REG_KD_TIMES_RATE: gain_d   = val;
      REG_STEP_LIMIT:    step_lim = val[LIM_W-1:0];
      REG_OUTPUT_LIMIT:  out_lim  = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_tick(input logic [DATA_W-1:0] err, input logic [DIST_W-1:0] tgt_dist);
    tick_t t;
    t.err      = err;
    t.tgt_dist = tgt_dist;
    tick_q = {tick_q, t};
  endtask

  // hold the source until every owed command has come back
  task automatic drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || cmd_q.size() != 0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset gains: extremes of both fields, output must stay at zero
    push_tick(32'h8000_0000, '0);
    push_tick(32'h7FFF_FFFF, '1);
    push_tick('0, DIST_W'(DB_NEAR_DIST - 1));
    push_tick(32'hFFFF_FFFF, DIST_W'(DB_NEAR_DIST));
    drain();

    // unity proportional gain: output follows the error, probing the deadband edges
    set_reg(REG_KP, 32'h0001_0000);
    end_writes();
    @(negedge clk_i);
    push_tick(DB_SMALL - 1, '1);
    push_tick(-(DB_SMALL - 1), '1);
    push_tick(DB_SMALL, DIST_W'(DB_NEAR_DIST - 1));
    push_tick(DB_SMALL, DIST_W'(DB_NEAR_DIST));
    push_tick(DB_WIDE - 1, DIST_W'(DB_NEAR_DIST - 1));
    push_tick(-(DB_WIDE - 1), '0);
    push_tick(DB_WIDE, '0);
    push_tick(-DB_WIDE, DIST_W'(DB_NEAR_DIST - 1));
    push_tick('0, '0);
    drain();

    // extreme gains with tight limits: step limit and clamp both engage
    set_reg(REG_KP, 32'h7FFF_FFFF);
    set_reg(REG_KI_PER_TICK, 32'h8000_0000);
    set_reg(REG_KD_TIMES_RATE, 32'h7FFF_FFFF);
    set_reg(REG_STEP_LIMIT, 32'h0001_8000);
    set_reg(REG_OUTPUT_LIMIT, 32'h0002_0000);
    end_writes();
    @(negedge clk_i);
    push_tick(32'h7FFF_FFFF, '1);
    push_tick(32'h7FFF_FFFF, '1);
    push_tick(32'h8000_0000, '1);
    push_tick(32'h8000_0000, '1);
    push_tick(32'h8000_0000, '0);
    push_tick(32'h0000_1000, '0);
    drain();

    // random phases, each with its own register setting and idling pattern
    for (int p = 0; p < 10; p++) begin
      set_reg(REG_KP, rand_gain());
      set_reg(REG_KI_PER_TICK, rand_gain());
      set_reg(REG_KD_TIMES_RATE, rand_gain());
      set_reg(REG_STEP_LIMIT, rand_limit());
      set_reg(REG_OUTPUT_LIMIT, rand_limit());
      // indexes past the register list must be ignored
      if (p % 3 == 0) begin
        for (int k = REG_OUTPUT_LIMIT + 1; k < (1 << CFG_IDX_W); k++) begin
          set_reg(CFG_IDX_W'(k), $urandom());
        end
      end
      end_writes();
      @(negedge clk_i);
      src_idle_on = (p == 0) || (p != 1 && $urandom_range(0, 3) != 0);
      snk_idle_on = (p == 0) || (p != 1 && $urandom_range(0, 3) != 0);
      for (int n = 0; n < 103; n++) begin
        tick_q = {tick_q, rand_tick()};
      end
      drain();
    end

    // let any stray output show up before the verdict
    repeat (12) @(posedge clk_i);
    if (fail_cnt == 0 && cmd_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
